>>> sv/shv_pkg.sv
`timescale 1ns / 1ps
package shv_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ChainDepth = 5;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned RoundCount = 80;

   localparam logic [WordWidth-1:0] IV0 = 32'h6745_2300;
   localparam logic [WordWidth-1:0] IV1 = 32'hEFCD_AB89;
   localparam logic [WordWidth-1:0] IV2 = 32'h98BA_DCFE;
   localparam logic [WordWidth-1:0] IV3 = 32'h1032_5475;
   localparam logic [WordWidth-1:0] IV4 = 32'hC3D2_E1EF;
   localparam logic [WordWidth-1:0] RK0 = 32'h05C2_7C99;
   localparam logic [WordWidth-1:0] RK1 = 32'h6AAA_EBA1;
   localparam logic [WordWidth-1:0] RK2 = 32'h2F1B_B5DC;
   localparam logic [WordWidth-1:0] RK3 = 32'hC5B2_C1D6;
   localparam logic [7:0] PadMark = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   // control from sequencer to round unit
   typedef struct packed {
      logic       load;   // copy chain into working vars
      logic       step;   // run one round
      logic [6:0] round;  // round number 0..79
   } rnd_ctrl_type;

   function automatic logic [WordWidth-1:0] iv_word(input logic [2:0] idx);
      case (idx)
         3'd0: iv_word = IV0;
         3'd1: iv_word = IV1;
         3'd2: iv_word = IV2;
         3'd3: iv_word = IV3;
         default: iv_word = IV4;
      endcase
   endfunction

endpackage

>>> sv/sha1_variant_hash_engine_core.sv
`timescale 1ns / 1ps
// Channel | Ports       | Payload
// request | req_t*      | tdata[7:0]=data_byte, tuser[0]=byte_present, tlast=end_of_message
// result  | rsp_t*      | tdata[31:0]=digest_word, tuser[2:0]=word_index, tlast=last_word
//
// A request with a byte is packed into the block buffer, and a byte that fills a block
// starts a compression (one load, 80 rounds on the shared round unit and one chaining fold).
// End of message: pad bytes go in one a cycle, each filled block is compressed,
// then five result words follow, one per accepted transfer.
// Reset (synchronous) restores the initial chain and clears counters.
// req_tready is low while compressing, padding or emitting; rsp stalls hold.
module sha1_variant_hash_engine_core
   import shv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_word
);

   state_type state_ff, state_in;
   logic [WordWidth-1:0] chain_ff [ChainDepth];
   logic [WordWidth-1:0] buf_ff [BlockWords];
   logic [5:0]  cnt_ff;
   logic [63:0] bits_ff, len_ff;
   logic [6:0]  round_ff;
   logic [2:0]  widx_ff;
   logic        ending_ff;   // padding in progress for this message
   logic        padlen_ff;   // 0x80 already placed
   logic        lenok_ff;    // current block takes the length field

   logic req_fire, rsp_fire;
   logic put_en;
   logic [7:0] put_byte;
   logic [WordWidth-1:0] sched_w;
   logic [WordWidth-1:0] sched_mix;
   logic [WordWidth-1:0] wa, wb, wc, wd, we;
   rnd_ctrl_type ctrl;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign sched_w = buf_ff[0];
   assign sched_mix = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser && cnt_ff == 6'd63) state_in = ST_ROUND;
               else if (req_tlast) state_in = ST_PAD;
            end
         end
         ST_ROUND: if (round_ff == 7'd80) state_in = ST_FOLD;
         ST_FOLD: begin
            if (ending_ff && lenok_ff) state_in = ST_EMIT;
            else if (ending_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD: if (cnt_ff == 6'd63) state_in = ST_ROUND;
         ST_EMIT: if (rsp_fire && widx_ff == 3'd4) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EMIT);
      ctrl.load  = (state_ff == ST_ROUND) && (round_ff == 7'd0);
      ctrl.step  = (state_ff == ST_ROUND) && (round_ff != 7'd0);
      ctrl.round = round_ff - 7'd1;
      put_en = 1'b0;
      put_byte = req_tdata;
      if (state_ff == ST_IDLE && req_fire && req_tuser) put_en = 1'b1;
      if (state_ff == ST_PAD) begin
         put_en = 1'b1;
         if (!padlen_ff) put_byte = PadMark;
         else if (lenok_ff && cnt_ff >= 6'd56)
            put_byte = len_ff[6'd63 - {cnt_ff[2:0], 3'd0} -: 8];
         else put_byte = 8'd0;
      end
   end

   assign rsp_tdata = chain_ff[widx_ff];
   assign rsp_tuser = widx_ff;
   assign rsp_tlast = (widx_ff == 3'd4);

   shv_round u_round (
      .clock(clock), .ctrl(ctrl),
      .chain_a(chain_ff[0]), .chain_b(chain_ff[1]), .chain_c(chain_ff[2]),
      .chain_d(chain_ff[3]), .chain_e(chain_ff[4]), .sched_w(sched_w),
      .work_a(wa), .work_b(wb), .work_c(wc), .work_d(wd), .work_e(we)
   );

   // block buffer: byte packing, then rotates as a 16-word schedule window
   always_ff @(posedge clock) begin
      if (put_en) begin
         case (cnt_ff[1:0])
            2'd0: buf_ff[cnt_ff[5:2]][31:24] <= put_byte;
            2'd1: buf_ff[cnt_ff[5:2]][23:16] <= put_byte;
            2'd2: buf_ff[cnt_ff[5:2]][15:8]  <= put_byte;
            default: buf_ff[cnt_ff[5:2]][7:0] <= put_byte;
         endcase
      end else if (ctrl.step) begin
         for (int i = 0; i < BlockWords - 1; i++) buf_ff[i] <= buf_ff[i+1];
         buf_ff[BlockWords-1] <= {sched_mix[30:0], sched_mix[31]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < ChainDepth; i++) chain_ff[i] <= iv_word(3'(i));
         cnt_ff <= '0;
         bits_ff <= '0;
         len_ff <= '0;
         round_ff <= '0;
         widx_ff <= '0;
         ending_ff <= 1'b0;
         padlen_ff <= 1'b0;
         lenok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (put_en) cnt_ff <= cnt_ff + 6'd1;
         if (state_ff == ST_IDLE && req_fire) begin
            if (req_tuser) bits_ff <= bits_ff + 64'd8;
            if (req_tlast) begin
               ending_ff <= 1'b1;
               padlen_ff <= 1'b0;
               len_ff <= req_tuser ? bits_ff + 64'd8 : bits_ff;
            end
         end
         if (state_ff == ST_PAD) padlen_ff <= 1'b1;
         // mark early enough in the block: length follows in the same block
         if (state_ff == ST_PAD && !padlen_ff && cnt_ff <= 6'd55) lenok_ff <= 1'b1;
         if (state_ff == ST_ROUND) round_ff <= round_ff + 7'd1;
         if (state_ff == ST_FOLD) begin
            round_ff <= '0;
            chain_ff[0] <= chain_ff[0] + wa;
            chain_ff[1] <= chain_ff[1] + wb;
            chain_ff[2] <= chain_ff[2] + wc;
            chain_ff[3] <= chain_ff[3] + wd;
            chain_ff[4] <= chain_ff[4] + we;
            // block with the mark is done: next block carries the length
            if (ending_ff && padlen_ff) lenok_ff <= 1'b1;
         end
         if (rsp_fire) begin
            if (widx_ff == 3'd4) begin
               widx_ff <= '0;
               for (int i = 0; i < ChainDepth; i++) chain_ff[i] <= iv_word(3'(i));
               bits_ff <= '0;
               ending_ff <= 1'b0;
               padlen_ff <= 1'b0;
               lenok_ff <= 1'b0;
            end else begin
               widx_ff <= widx_ff + 3'd1;
            end
         end
      end
   end

   a_emit_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> widx_ff <= 3'd4) else $error("bad word index");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while emitting");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> state_ff == ST_IDLE) else $error("no idle after digest");

endmodule

>>> sv/shv_round.sv
`timescale 1ns / 1ps
module shv_round
   import shv_pkg::*;
(
   input  logic                        clock,
   input  rnd_ctrl_type                ctrl,
   input  logic [WordWidth-1:0]        chain_a,
   input  logic [WordWidth-1:0]        chain_b,
   input  logic [WordWidth-1:0]        chain_c,
   input  logic [WordWidth-1:0]        chain_d,
   input  logic [WordWidth-1:0]        chain_e,
   input  logic [WordWidth-1:0]        sched_w,
   output logic [WordWidth-1:0]        work_a,
   output logic [WordWidth-1:0]        work_b,
   output logic [WordWidth-1:0]        work_c,
   output logic [WordWidth-1:0]        work_d,
   output logic [WordWidth-1:0]        work_e
);

   logic [WordWidth-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WordWidth-1:0] a_in, b_in, c_in, d_in, e_in;
   logic [WordWidth-1:0] f_val, k_val;

   // round function and constant
   always_comb begin
      if (ctrl.round < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = RK0;
      end else if (ctrl.round < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = RK1;
      end else if (ctrl.round < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = RK2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = RK3;
      end
   end

   // next working vars
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctrl.load) begin
         a_in = chain_a;
         b_in = chain_b;
         c_in = chain_c;
         d_in = chain_d;
         e_in = chain_e;
      end else if (ctrl.step) begin
         a_in = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + sched_w;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign work_a = a_ff;
   assign work_b = b_ff;
   assign work_c = c_ff;
   assign work_d = d_ff;
   assign work_e = e_ff;

endmodule
